### src/lla_pkg.sv
// shared types and constants for the loas/latm to adts converter
`default_nettype none
package lla_pkg;

    // depth of the command queue between the parser and the emitter
    localparam int QUEUE_DEPTH = 4;

    // loas sync word and adts header constants
    localparam logic [10:0] LOAS_SYNC  = 11'h2B7;
    localparam logic [7:0]  ADTS_SYNC0 = 8'hFF;
    localparam logic [7:0]  ADTS_SYNC1 = 8'hF1;
    localparam logic [12:0] ADTS_HDR_LEN = 13'd7;
    localparam logic [7:0]  SLOT_ESCAPE = 8'd255;
    localparam logic [3:0]  RATE_FORBIDDEN = 4'hF;

    // one command from the parser: a whole adts header or one payload byte
    typedef struct packed {
        logic        hdr;
        logic [12:0] slot;
        logic [3:0]  rate;
        logic [2:0]  chan;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

endpackage
`default_nettype wire

### src/lla_queue.sv
// small command queue between the parser and the emitter
`default_nettype none
module lla_queue #(
    parameter int WIDTH = 30,
    parameter int DEPTH = lla_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("queue count out of range");

endmodule
`default_nettype wire

### src/lla_front.sv
// loas sync hunt and latm bit parser, issues header and payload commands
`default_nettype none
module lla_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_ts,
    input  wire logic        i_full,
    output logic             o_ready,
    output logic             o_push,
    output lla_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        PH_HUNT, PH_LEN, PH_USE_SAME, PH_MUX_VER, PH_MUX_FIXED, PH_AOT, PH_RATE,
        PH_CHAN, PH_FLF, PH_DEPENDS, PH_CORE, PH_EXT, PH_EXT3, PH_FLT, PH_FLT_DATA,
        PH_OTHER, PH_OTHER_ESC, PH_OTHER_MORE, PH_OTHER_LAST, PH_CRC, PH_CRC_BYTE,
        PH_SLOT, PH_PAYLOAD, PH_SKIP
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  win;
        logic [3:0]  fleft;
        logic [12:0] slot;
        logic [12:0] pleft;
        logic [3:0]  rate;
        logic [2:0]  chan;
        logic        muxv;
    } t_fs;

    typedef struct packed {
        t_fs           s;
        logic          ev;
        lla_pkg::t_cmd cmd;
    } t_step;

    function automatic t_fs enter(t_fs s, t_phase ph, logic [3:0] n);
        t_fs r;
        r = s;
        r.phase = ph;
        r.fleft = n;
        r.win = '0;
        return r;
    endfunction

    // one bit through the field parser
    function automatic t_step bit_step(t_fs s, logic b, logic ts, logic [12:0] fbl);
        t_step r;
        logic [7:0] v;
        logic [13:0] sum;
        logic [12:0] sl;
        logic [12:0] pl;
        r.s = s;
        r.ev = 1'b0;
        r.cmd = '0;
        v = '0;
        sum = '0;
        sl = '0;
        pl = '0;
        if (s.phase != PH_HUNT && s.phase != PH_LEN && s.phase != PH_SKIP) begin
            r.s.win = {s.win[6:0], b};
            if (s.fleft != '0) begin
                r.s.fleft = s.fleft - 1'b1;
            end
            if (r.s.fleft == '0) begin
                v = r.s.win;
                unique case (s.phase)
                    PH_USE_SAME: begin
                        if (v[0] == 1'b0) begin
                            r.s = enter(r.s, PH_MUX_VER, 4'd1);
                        end else if (s.muxv || s.rate == lla_pkg::RATE_FORBIDDEN) begin
                            r.s.phase = PH_SKIP;
                        end else begin
                            r.s = enter(r.s, PH_SLOT, 4'd8);
                        end
                    end
                    PH_MUX_VER: begin
                        r.s.muxv = v[0];
                        if (v[0]) begin
                            r.s.phase = PH_SKIP;
                        end else begin
                            r.s = enter(r.s, PH_MUX_FIXED, 4'd14);
                        end
                    end
                    PH_MUX_FIXED: r.s = enter(r.s, PH_AOT, 4'd5);
                    PH_AOT:       r.s = enter(r.s, PH_RATE, 4'd4);
                    PH_RATE: begin
                        r.s.rate = v[3:0];
                        if (v[3:0] == lla_pkg::RATE_FORBIDDEN) begin
                            r.s.phase = PH_SKIP;
                        end else begin
                            r.s = enter(r.s, PH_CHAN, 4'd4);
                        end
                    end
                    PH_CHAN: begin
                        r.s.chan = v[3] ? 3'd0 : v[2:0];
                        r.s = enter(r.s, PH_FLF, 4'd1);
                    end
                    PH_FLF: r.s = enter(r.s, PH_DEPENDS, 4'd1);
                    PH_DEPENDS: begin
                        if (v[0]) begin
                            r.s = enter(r.s, PH_CORE, 4'd14);
                        end else begin
                            r.s = enter(r.s, PH_EXT, 4'd1);
                        end
                    end
                    PH_CORE: r.s = enter(r.s, PH_EXT, 4'd1);
                    PH_EXT: begin
                        if (v[0]) begin
                            r.s = enter(r.s, PH_EXT3, 4'd1);
                        end else begin
                            r.s = enter(r.s, PH_FLT, 4'd3);
                        end
                    end
                    PH_EXT3: r.s = enter(r.s, PH_FLT, 4'd3);
                    PH_FLT: begin
                        case (v[2:0])
                            3'd0:                r.s = enter(r.s, PH_FLT_DATA, 4'd8);
                            3'd1:                r.s = enter(r.s, PH_FLT_DATA, 4'd9);
                            3'd2:                r.s = enter(r.s, PH_OTHER, 4'd1);
                            3'd3, 3'd4, 3'd5:    r.s = enter(r.s, PH_FLT_DATA, 4'd6);
                            default:             r.s = enter(r.s, PH_FLT_DATA, 4'd1);
                        endcase
                    end
                    PH_FLT_DATA: r.s = enter(r.s, PH_OTHER, 4'd1);
                    PH_OTHER: begin
                        if (v[0]) begin
                            r.s = enter(r.s, PH_OTHER_ESC, 4'd1);
                        end else begin
                            r.s = enter(r.s, PH_CRC, 4'd1);
                        end
                    end
                    PH_OTHER_ESC: begin
                        r.s = enter(r.s, v[0] ? PH_OTHER_MORE : PH_OTHER_LAST, 4'd8);
                    end
                    PH_OTHER_MORE: r.s = enter(r.s, PH_OTHER_ESC, 4'd1);
                    PH_OTHER_LAST: r.s = enter(r.s, PH_CRC, 4'd1);
                    PH_CRC: begin
                        if (v[0]) begin
                            r.s = enter(r.s, PH_CRC_BYTE, 4'd8);
                        end else begin
                            r.s = enter(r.s, PH_SLOT, 4'd8);
                        end
                    end
                    PH_CRC_BYTE: r.s = enter(r.s, PH_SLOT, 4'd8);
                    PH_SLOT: begin
                        // escaped slot length, saturating at the field maximum
                        sum = {1'b0, s.slot} + {6'd0, v};
                        sl = sum[13] ? '1 : sum[12:0];
                        r.s.slot = sl;
                        if (v == lla_pkg::SLOT_ESCAPE) begin
                            r.s = enter(r.s, PH_SLOT, 4'd8);
                        end else if (sl > fbl || !ts) begin
                            r.s.phase = PH_SKIP;
                        end else begin
                            r.ev = 1'b1;
                            r.cmd.hdr = 1'b1;
                            r.cmd.slot = sl;
                            r.cmd.rate = s.rate;
                            r.cmd.chan = s.chan;
                            if (sl == '0) begin
                                r.s.phase = PH_SKIP;
                            end else begin
                                r.s.pleft = sl;
                                r.s = enter(r.s, PH_PAYLOAD, 4'd8);
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        pl = (s.pleft != '0) ? s.pleft - 1'b1 : s.pleft;
                        r.s.pleft = pl;
                        r.ev = 1'b1;
                        r.cmd.data = v;
                        r.cmd.last = (pl == '0);
                        if (pl == '0) begin
                            r.s.phase = PH_SKIP;
                        end else begin
                            r.s = enter(r.s, PH_PAYLOAD, 4'd8);
                        end
                    end
                    default: r.s = s;
                endcase
            end
        end
        return r;
    endfunction

    t_fs           r_s, n_s;
    logic [12:0]   r_fbl, n_fbl;
    logic          r_have, n_have;
    logic          accept;
    logic [12:0]   fbl_dec;
    logic [12:0]   len_new;
    t_step         st [9];
    lla_pkg::t_cmd cmd;
    logic          ev;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign fbl_dec = (r_fbl != '0) ? r_fbl - 1'b1 : r_fbl;
    assign len_new = {r_s.win[4:0], i_byte};

    // eight bit steps of the current byte, at most one command comes out
    always_comb begin
        st[0].s = r_s;
        st[0].ev = 1'b0;
        st[0].cmd = '0;
        ev = 1'b0;
        cmd = '0;
        for (int i = 0; i < 8; i++) begin
            st[i+1] = bit_step(st[i].s, i_byte[7-i], i_ts, fbl_dec);
            if (st[i+1].ev) begin
                ev = 1'b1;
                cmd = st[i+1].cmd;
            end
        end
    end

    // next parser state per byte
    always_comb begin
        n_s = r_s;
        n_fbl = r_fbl;
        n_have = r_have;
        if (r_s.phase == PH_HUNT) begin
            if (r_have && {r_s.win, i_byte[7:5]} == lla_pkg::LOAS_SYNC) begin
                n_s.phase = PH_LEN;
            end
            n_s.win = i_byte;
            n_have = 1'b1;
        end else if (r_s.phase == PH_LEN) begin
            n_fbl = len_new;
            n_s.slot = '0;
            n_s.pleft = '0;
            n_have = 1'b0;
            if (len_new == '0) begin
                n_s.phase = PH_HUNT;
                n_s.win = '0;
            end else begin
                n_s = enter(n_s, PH_USE_SAME, 4'd1);
            end
        end else begin
            n_fbl = fbl_dec;
            n_s = st[8].s;
            if (fbl_dec == '0) begin
                n_s.phase = PH_HUNT;
                n_s.win = '0;
                n_s.fleft = '0;
                n_have = 1'b0;
            end
        end
    end

    assign o_push = accept && ev && r_s.phase != PH_HUNT && r_s.phase != PH_LEN;
    assign o_cmd  = cmd;

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s    <= '{phase: PH_HUNT, default: '0};
            r_fbl  <= '0;
            r_have <= 1'b0;
        end else if (accept) begin
            r_s    <= n_s;
            r_fbl  <= n_fbl;
            r_have <= n_have;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("command pushed into a full queue");
    a_len_after_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s.phase == PH_LEN) |-> $past(r_s.phase) == PH_HUNT || $past(r_s.phase) == PH_LEN)
        else $error("length phase not reached from hunt");
    a_hunt_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s.phase == PH_HUNT) |-> !o_push) else $error("command while hunting");

endmodule
`default_nettype wire

### src/lla_back.sv
// adts emitter: expands header commands into seven bytes, passes payload bytes
`default_nettype none
module lla_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  lla_pkg::t_cmd      i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last
);
    localparam logic [2:0] HDR_LAST_IDX = 3'd6;

    logic [2:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        fire;
    logic [12:0] len;
    logic [7:0]  hbyte;
    logic        hlast;

    assign fire = !i_empty && (!r_valid || i_ready);
    assign o_pop = fire && (!i_cmd.hdr || r_idx == HDR_LAST_IDX);
    assign len = i_cmd.slot + lla_pkg::ADTS_HDR_LEN;

    // header byte selection
    always_comb begin
        hlast = 1'b0;
        unique case (r_idx)
            3'd0: hbyte = lla_pkg::ADTS_SYNC0;
            3'd1: hbyte = lla_pkg::ADTS_SYNC1;
            3'd2: hbyte = {2'b01, i_cmd.rate, 1'b1, i_cmd.chan[2]};
            3'd3: hbyte = {i_cmd.chan[1:0], 4'hF, len[12:11]};
            3'd4: hbyte = len[10:3];
            3'd5: hbyte = {len[2:0], 5'd0};
            3'd6: begin
                hbyte = 8'd0;
                hlast = (i_cmd.slot == '0);
            end
            default: hbyte = 8'd0;
        endcase
    end

    // output register and header byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 3'd0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= i_cmd.hdr ? hbyte : i_cmd.data;
            r_last <= i_cmd.hdr ? hlast : i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= HDR_LAST_IDX) else $error("header index out of range");
    a_idx_holds_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (!i_empty && i_cmd.hdr)) else $error("header lost mid burst");
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_valid) else $error("emitted byte not held");

endmodule
`default_nettype wire

### src/loas_latm_to_adts_converter.sv
// top level: loas/latm byte stream in, adts byte stream out
// path: a command passes the command queue, then the emitter output register
// throughput: one input beat per cycle; one output beat per ready cycle, a header is
//   seven beats, the command queue absorbs header bursts and stalls the input when full
// reset: synchronous active low, parser returns to sync hunt, queue and output empty
`default_nettype none
module loas_latm_to_adts_converter #(
    parameter int QUEUE_DEPTH = lla_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tuser,   // [0] timestamp_valid
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast
);
    localparam int CW = $bits(lla_pkg::t_cmd);

    logic          push, pop, full, empty;
    lla_pkg::t_cmd push_cmd, head_cmd;
    logic [CW-1:0] head_bits;

    // parser
    lla_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_ts    (i_s_axis_tuser),
        .i_full  (full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // command queue
    lla_queue #(.WIDTH(CW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_full  (full),
        .o_empty (empty)
    );

    assign head_cmd = lla_pkg::t_cmd'(head_bits);

    // emitter
    lla_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

### verif/loas_latm_to_adts_converter_test.sv
// self-checking testbench for the loas/latm to adts converter
`default_nettype none
module loas_latm_to_adts_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    // parser phases of the predictor
    typedef enum int {
        P_HUNT, P_LEN, P_USE_SAME, P_MUX_VER, P_MUX_FIXED, P_AOT, P_RATE, P_CHAN,
        P_FLF, P_DEPENDS, P_CORE, P_EXT, P_EXT3, P_FLT, P_FLT_DATA, P_OTHER,
        P_OTHER_ESC, P_OTHER_MORE, P_OTHER_LAST, P_CRC, P_CRC_BYTE, P_SLOT,
        P_PAYLOAD, P_SKIP
    } t_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'd0;  // [7:0] in_byte
    logic       i_s_axis_tuser = 1'b0;  // [0] timestamp_valid
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;         // [7:0] out_byte
    logic       o_m_axis_tlast;

    loas_latm_to_adts_converter dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    t_phase      ph;
    logic [15:0] win;
    int          held, fbits, frame_left, slot, pay_left;
    logic [3:0]  rate;
    logic [2:0]  chan;
    logic        mux_v;

    logic [8:0] adts_queue[$];   // {last, byte}
    int errors = 0, sent = 0, got = 0, frames = 0;
    bit hold_off = 0, stall_sink = 0;

    task automatic go(t_phase p, int n);
        ph = p; fbits = n; win = '0;
    endtask

    task automatic push(logic [7:0] b, logic l);
        adts_queue.push_back({l, b});
    endtask

    task automatic emit_adts_header();
        logic [12:0] len;
        len = 13'(slot + 7);
        push(8'hFF, 0); push(8'hF1, 0);
        push({2'b01, rate, 1'b1, chan[2]}, 0);
        push({chan[1:0], 4'hF, len[12:11]}, 0);
        push(len[10:3], 0);
        push({len[2:0], 5'd0}, 0);
        push(8'h00, slot == 0);
        frames++;
    endtask

    task automatic parse_bit(logic b, logic ts);
        logic [15:0] v;
        if (ph < P_USE_SAME || ph > P_PAYLOAD) return;
        win = {win[14:0], b};
        if (fbits > 0) fbits--;
        if (fbits != 0) return;
        v = win;
        case (ph)
            P_USE_SAME:
                if (v == 0) go(P_MUX_VER, 1);
                else if (mux_v || rate == 4'hF) ph = P_SKIP;
                else go(P_SLOT, 8);
            P_MUX_VER: begin
                mux_v = v[0];
                if (mux_v) ph = P_SKIP; else go(P_MUX_FIXED, 14);
            end
            P_MUX_FIXED: go(P_AOT, 5);
            P_AOT: go(P_RATE, 4);
            P_RATE: begin
                rate = v[3:0];
                if (rate == 4'hF) ph = P_SKIP; else go(P_CHAN, 4);
            end
            P_CHAN: begin
                chan = (v > 7) ? 3'd0 : v[2:0];
                go(P_FLF, 1);
            end
            P_FLF: go(P_DEPENDS, 1);
            P_DEPENDS: if (v != 0) go(P_CORE, 14); else go(P_EXT, 1);
            P_CORE: go(P_EXT, 1);
            P_EXT: if (v != 0) go(P_EXT3, 1); else go(P_FLT, 3);
            P_EXT3: go(P_FLT, 3);
            P_FLT:
                if (v == 0) go(P_FLT_DATA, 8);
                else if (v == 1) go(P_FLT_DATA, 9);
                else if (v == 2) go(P_OTHER, 1);
                else if (v <= 5) go(P_FLT_DATA, 6);
                else go(P_FLT_DATA, 1);
            P_FLT_DATA: go(P_OTHER, 1);
            P_OTHER: if (v != 0) go(P_OTHER_ESC, 1); else go(P_CRC, 1);
            P_OTHER_ESC: go(v != 0 ? P_OTHER_MORE : P_OTHER_LAST, 8);
            P_OTHER_MORE: go(P_OTHER_ESC, 1);
            P_OTHER_LAST: go(P_CRC, 1);
            P_CRC: if (v != 0) go(P_CRC_BYTE, 8); else go(P_SLOT, 8);
            P_CRC_BYTE: go(P_SLOT, 8);
            P_SLOT: begin
                slot += v[7:0];
                if (slot > 8191) slot = 8191;
                if (v[7:0] == 8'd255) go(P_SLOT, 8);
                else if (slot > frame_left || !ts) ph = P_SKIP;
                else begin
                    emit_adts_header();
                    if (slot == 0) ph = P_SKIP;
                    else begin
                        pay_left = slot;
                        go(P_PAYLOAD, 8);
                    end
                end
            end
            default: begin
                if (pay_left > 0) pay_left--;
                push(v[7:0], pay_left == 0);
                if (pay_left == 0) ph = P_SKIP; else go(P_PAYLOAD, 8);
            end
        endcase
    endtask

    // advance the predictor by one accepted loas byte
    task automatic predict_adts(logic [7:0] b, logic ts);
        if (ph == P_HUNT) begin
            win = {win[7:0], b};
            held = (held >= 8) ? 16 : held + 8;
            if (held >= 16 && win[15:5] == 11'h2B7) ph = P_LEN;
            return;
        end
        if (ph == P_LEN) begin
            frame_left = {win[4:0], b};
            slot = 0; pay_left = 0; held = 0;
            if (frame_left == 0) begin
                ph = P_HUNT; win = '0;
            end else go(P_USE_SAME, 1);
            return;
        end
        if (frame_left > 0) frame_left--;
        for (int i = 7; i >= 0; i--) parse_bit(b[i], ts);
        if (frame_left == 0) begin
            ph = P_HUNT; win = '0; held = 0; fbits = 0;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one loas byte, wait for its beat; valid stays up for a following beat
    task automatic send_byte(logic [7:0] b, logic ts = 1'b1);
        int g;
        g = hold_off ? 0 : gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= ts;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_adts(b, ts);
        sent++;
        @(negedge i_clk);
    endtask

    // stop offering beats after the last byte of a sequence
    task automatic idle_input();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // sink readiness: random stalls, or a long forced stall
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_sink) i_m_axis_tready <= 1'b0;
        else if (hold_off) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= ($urandom_range(0, 9) < 7)
                                || ($urandom_range(0, 19) == 0 ? 1'b0 : 1'b0);
    end

    // compare each adts beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got++;
            if (adts_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat data=%h last=%b", $realtime,
                         o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                logic [8:0] e;
                e = adts_queue.pop_front();
                if (o_m_axis_tdata !== e[7:0] || o_m_axis_tlast !== e[8]) begin
                    errors++;
                    $display("%0t: mismatch expected data=%h last=%b actual data=%h last=%b",
                             $realtime, e[7:0], e[8], o_m_axis_tdata, o_m_axis_tlast);
                end
            end
        end
    end

    // bit buffer for building latm payloads
    bit bitbuf[$];
    task automatic put_bits(int v, int n);
        for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
    endtask

    // build and send one loas frame
    // reuse: 0 fresh config, 1 reuse config
    task automatic send_frame(bit reuse, int mux = 0, int rt = 4, int ch = 2,
                              int slotlen = 4, int len_adj = 0, bit ts = 1,
                              bit rnd_opts = 1);
        byte unsigned bytes[$];
        int flen, flt;
        bitbuf.delete();
        put_bits(reuse, 1);
        if (!reuse) begin
            put_bits(mux, 1);
            if (mux == 0) begin
                put_bits($urandom, 14); put_bits($urandom, 5);
                put_bits(rt, 4); put_bits(ch, 4); put_bits($urandom, 1);
                if (rnd_opts && $urandom_range(0, 3) == 0) begin
                    put_bits(1, 1); put_bits($urandom, 14);
                end else put_bits(0, 1);
                if (rnd_opts && $urandom_range(0, 3) == 0) begin
                    put_bits(1, 1); put_bits($urandom, 1);
                end else put_bits(0, 1);
                flt = rnd_opts ? $urandom_range(0, 7) : 0;
                put_bits(flt, 3);
                case (flt)
                    0: put_bits($urandom, 8);
                    1: put_bits($urandom, 9);
                    2: ;
                    3, 4, 5: put_bits($urandom, 6);
                    default: put_bits($urandom, 1);
                endcase
                if (rnd_opts && $urandom_range(0, 2) == 0) begin
                    put_bits(1, 1);
                    repeat ($urandom_range(0, 2)) begin
                        put_bits(1, 1); put_bits($urandom, 8);
                    end
                    put_bits(0, 1); put_bits($urandom, 8);
                end else put_bits(0, 1);
                if (rnd_opts && $urandom_range(0, 1)) begin
                    put_bits(1, 1); put_bits($urandom, 8);
                end else put_bits(0, 1);
            end
        end
        // escaped slot length
        begin
            int s;
            s = slotlen;
            while (s >= 255) begin put_bits(255, 8); s -= 255; end
            put_bits(s, 8);
        end
        repeat (slotlen * 8) bitbuf.push_back($urandom_range(0, 1));
        while (bitbuf.size() % 8 != 0) bitbuf.push_back($urandom_range(0, 1));
        while (bitbuf.size() > 0) begin
            byte unsigned x;
            for (int i = 0; i < 8; i++) x = {x[6:0], bitbuf.pop_front()};
            bytes.push_back(x);
        end
        flen = bytes.size() + len_adj;
        if (flen < 1) flen = 1;
        if (flen > 8191) flen = 8191;
        // two fresh bytes are needed after any frame before sync
        send_byte(8'h00, ts);
        send_byte(8'h56, ts);
        send_byte({3'b111, 5'(flen >> 8)}, ts);
        send_byte(8'(flen), ts);
        for (int i = 0; i < flen; i++)
            send_byte(i < bytes.size() ? bytes[i] : 8'($urandom), ts);
    endtask

    task automatic wait_drained();
        int t;
        t = 0;
        while (adts_queue.size() != 0 && t < 20000) begin
            @(posedge i_clk); t++;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_frame(1, 0, 4, 2, 3, 0, 1, 0);          // reuse before any config
        send_frame(0, 0, 0, 0, 0, 0, 1, 0);          // empty slot
        send_frame(0, 0, 14, 7, 1, 0, 1, 1);
        send_frame(0, 0, 3, 9, 2, 0, 1, 1);          // channel index above seven
        send_frame(0, 0, 5, 1, 5, -3, 1, 1);         // slot overrun
        send_frame(0, 0, 5, 1, 5, 0, 0, 1);          // invalid timestamp
        send_frame(0, 0, 15, 2, 2, 0, 1, 0);         // rate index fifteen
        send_frame(1, 0, 4, 2, 2, 0, 1, 0);          // reuse after rate fifteen
        send_frame(0, 1, 4, 2, 2, 0, 1, 0);          // mux version one
        send_frame(1, 0, 4, 2, 2, 0, 1, 0);
        send_frame(0, 0, 6, 2, 260, 0, 1, 0);        // escaped slot length
        send_byte(8'h56); send_byte(8'hE0); send_byte(8'h00); // zero frame length
        send_byte(8'hFF, 0); send_byte(8'h00, 0);
        send_frame(0, 0, 4, 2, 8, -6, 1, 1);         // truncated frame
        idle_input();
        wait_drained();
    endtask

    task automatic test_backpressure();
        stall_sink = 1; hold_off = 1;
        fork
            begin repeat (150) @(negedge i_clk); stall_sink = 0; end
            begin
                send_frame(0, 0, 4, 2, 20, 0, 1, 0);
                send_frame(1, 0, 4, 2, 20, 0, 1, 0);
                idle_input();
            end
        join
        hold_off = 0;
        wait_drained();
    endtask

    task automatic test_random();
        while (sent < 520 && frames < 60) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 8) repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
            else send_frame(r < 40, (r % 17) == 0, (r % 13 == 0) ? 15 : $urandom_range(0, 14),
                            $urandom_range(0, 15), $urandom_range(0, 12),
                            (r % 11 == 0) ? -$urandom_range(1, 4) : $urandom_range(0, 3),
                            (r % 19) != 0, 1);
        end
        idle_input();
        wait_drained();
    endtask

    initial begin
        ph = P_HUNT; win = '0; held = 0; fbits = 0; frame_left = 0; slot = 0;
        pay_left = 0; rate = '0; chan = '0; mux_v = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        $display("covered %0d loas bytes and %0d adts frames (%0d beats)", sent, frames, got);
        if (errors == 0 && adts_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0t: %0d beats still expected, %0d errors", $realtime,
                     adts_queue.size(), errors);
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
src/lla_pkg.sv
src/lla_queue.sv
src/lla_front.sv
src/lla_back.sv
src/loas_latm_to_adts_converter.sv
verif/loas_latm_to_adts_converter_test.sv
